// ===== rtl/core/stxrx_pkg.sv =====
`default_nettype none
package stxrx_pkg;

   localparam int FRAME_BUFFER_BYTES = 64;
   localparam int COUNT_W            = $clog2(FRAME_BUFFER_BYTES + 1);
   localparam int STORE_INDEX_W      = 6;
   localparam int FRAME_LENGTH_W     = 7;
   localparam int BYTE_W             = 8;
   localparam int CSR_INDEX_W        = 8;

   localparam logic [COUNT_W-1:0] OVF_LIMIT = COUNT_W'(FRAME_BUFFER_BYTES - 2);

   localparam logic [CSR_INDEX_W-1:0] CSR_START_CODE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE   = CSR_INDEX_W'(1);

   localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'h02;
   localparam logic [BYTE_W-1:0] END_CODE_RESET   = 8'h03;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_CHECK   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_code;
      logic [BYTE_W-1:0] end_code;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]         byte_echo;
      logic                      store_valid;
      logic [STORE_INDEX_W-1:0]  store_index;
      logic                      frame_done;
      logic                      check_ok;
      logic [BYTE_W-1:0]         computed_check;
      logic [FRAME_LENGTH_W-1:0] frame_length;
      logic                      overflow_abort;
   } rsp_type;

   // bit 7 becomes odd parity over bits 6..0
   function automatic logic [BYTE_W-1:0] odd_parity_check(input logic [BYTE_W-1:0] v);
      return {~^v[6:0], v[6:0]};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/stxrx_csr.sv =====
`default_nettype none
module stxrx_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [stxrx_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [stxrx_pkg::BYTE_W-1:0]        csr_wdata,
   output stxrx_pkg::cfg_type                       cfg
);
   import stxrx_pkg::*;

   logic [BYTE_W-1:0] start_code_ff;
   logic [BYTE_W-1:0] end_code_ff;
   logic              wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RESET;
         end_code_ff   <= END_CODE_RESET;
      end else if (wr_en) begin
         if (csr_index == CSR_START_CODE) begin
            start_code_ff <= csr_wdata;
         end
         if (csr_index == CSR_END_CODE) begin
            end_code_ff <= csr_wdata;
         end
      end
   end

   assign cfg.start_code = start_code_ff;
   assign cfg.end_code   = end_code_ff;

endmodule
`default_nettype wire

// ===== rtl/core/stxrx_framer.sv =====
`default_nettype none
module stxrx_framer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_en,
   input  wire logic [stxrx_pkg::BYTE_W-1:0]  rx_byte,
   input  wire stxrx_pkg::cfg_type            cfg,
   output stxrx_pkg::rsp_type                 res
);
   import stxrx_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]  running_xor_ff, running_xor_in;
   logic [COUNT_W-1:0] idx;
   logic [BYTE_W-1:0]  chk;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_count_ff  <= '0;
         running_xor_ff <= '0;
      end else if (item_en) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      running_xor_in = running_xor_ff;
      idx            = '0;
      chk            = '0;
      res            = '0;
      res.byte_echo  = rx_byte;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == cfg.start_code) begin
               res.store_valid = 1'b1;
               byte_count_in   = COUNT_W'(1);
               running_xor_in  = '0;
               phase_in        = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (byte_count_ff > OVF_LIMIT) begin
               res.overflow_abort = 1'b1;
               phase_in           = PH_IDLE;
            end else begin
               res.store_valid = 1'b1;
               if (rx_byte == cfg.start_code) begin
                  // restart: stored at index 0
                  byte_count_in  = COUNT_W'(1);
                  running_xor_in = '0;
               end else begin
                  idx            = byte_count_ff;
                  byte_count_in  = byte_count_ff + COUNT_W'(1);
                  running_xor_in = running_xor_ff ^ rx_byte;
                  if (rx_byte == cfg.end_code) begin
                     phase_in = PH_CHECK;
                  end
               end
            end
         end
         PH_CHECK: begin
            idx                = byte_count_ff;
            byte_count_in      = byte_count_ff + COUNT_W'(1);
            chk                = odd_parity_check(running_xor_ff);
            res.store_valid    = 1'b1;
            res.frame_done     = 1'b1;
            res.check_ok       = (rx_byte == chk);
            res.computed_check = chk;
            res.frame_length   = FRAME_LENGTH_W'(byte_count_in);
            phase_in           = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      res.store_index = STORE_INDEX_W'(idx);
   end

   a_check_returns_idle: assert property (@(posedge clock) disable iff (reset)
      item_en && phase_ff == PH_CHECK |=> phase_ff == PH_IDLE)
      else $error("check byte did not close the frame");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= COUNT_W'(FRAME_BUFFER_BYTES))
      else $error("byte count past buffer size");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !item_en |=> $stable(phase_ff) && $stable(byte_count_ff) && $stable(running_xor_ff))
      else $error("frame state moved without an item");

   a_abort_leaves_payload: assert property (@(posedge clock) disable iff (reset)
      item_en && res.overflow_abort |=> phase_ff == PH_IDLE && !$stable(phase_ff))
      else $error("overflow did not abort the frame");

endmodule
`default_nettype wire

// ===== rtl/core/stx_etx_bcc_frame_receiver.sv =====
// STX/ETX/BCC frame receiver.
// Request channel (req_valid/req_ready/req_rx_byte) takes one received byte
// per item. Response channel (rsp_*) returns exactly one result item per byte:
// the echoed byte, whether and where it goes into the external frame buffer,
// and on the check byte the frame status (computed check, match, length).
// Configuration channel (csr_*) writes start code (index 0) and end code
// (index 1); always ready, to be written only while no item is in flight.
// Path: an accepted byte sits in the input register, and the framer result
// for it is loaded into the result register that drives the rsp_* outputs.
// Throughput: one item per cycle while rsp_ready is high; the frame state is
// updated in the same cycle the result register loads.
// When rsp_ready is low the result register holds, the input register
// still takes one more byte, then req_ready drops until the result drains.
// Reset (synchronous) empties both registers, returns to waiting for the
// start code and restores start code 0x02 and end code 0x03.
`default_nettype none
module stx_etx_bcc_frame_receiver (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [stxrx_pkg::BYTE_W-1:0]          req_rx_byte,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [stxrx_pkg::BYTE_W-1:0]               rsp_byte_echo,
   output logic                                       rsp_store_valid,
   output logic [stxrx_pkg::STORE_INDEX_W-1:0]        rsp_store_index,
   output logic                                       rsp_frame_done,
   output logic                                       rsp_check_ok,
   output logic [stxrx_pkg::BYTE_W-1:0]               rsp_computed_check,
   output logic [stxrx_pkg::FRAME_LENGTH_W-1:0]       rsp_frame_length,
   output logic                                       rsp_overflow_abort,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [stxrx_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [stxrx_pkg::BYTE_W-1:0]          csr_wdata
);
   import stxrx_pkg::*;

   cfg_type           cfg;
   rsp_type           res;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] rx_ff;
   logic              advance;
   logic              item_en;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign item_en   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   stxrx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   stxrx_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .item_en (item_en),
      .rx_byte (rx_ff),
      .cfg     (cfg),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rx_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_en) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_echo      = rsp_ff.byte_echo;
   assign rsp_store_valid    = rsp_ff.store_valid;
   assign rsp_store_index    = rsp_ff.store_index;
   assign rsp_frame_done     = rsp_ff.frame_done;
   assign rsp_check_ok       = rsp_ff.check_ok;
   assign rsp_computed_check = rsp_ff.computed_check;
   assign rsp_frame_length   = rsp_ff.frame_length;
   assign rsp_overflow_abort = rsp_ff.overflow_abort;

endmodule
`default_nettype wire
